// ----- sv/potb_pkg.sv -----
// Shared types and constants for the periodic/one-shot timer bank.
package potb_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int LIMIT_W   = 5;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  localparam logic [1:0] EV_CREATED = 2'd0;
  localparam logic [1:0] EV_REFUSED = 2'd1;
  localparam logic [1:0] EV_TIMEOUT = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [30:0] init_count;
    logic        one_shot;
  } item_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [3:0] timer_index;
    logic       last;
  } item_out_t;

  typedef struct packed {
    logic [30:0]        reload;
    logic signed [31:0] count;
    logic               one_shot;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

// ----- sv/potb_store.sv -----
// Timer entry memory: one write port, one registered read port.
module potb_store
  import potb_pkg::*;
(
  input  logic     clk,
  input  mem_req_t mreq,
  output entry_t   rd_data
);

  entry_t mem [NUM_SLOTS];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
    if (mreq.rd_en) begin
      rd_data <= mem[mreq.rd_addr];
    end
  end

endmodule

// ----- sv/potb_ctrl.sv -----
// Sequencer: slot allocation, tick walk over the entry memory, result output.
module potb_ctrl
  import potb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  item_in_t           request,
  input  logic [LIMIT_W-1:0] pool_limit,
  output logic               busy,
  output logic               done,
  output item_out_t          result,
  output mem_req_t           mreq,
  input  entry_t             rd_data
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_t;

  state_t               state;
  logic [CNT_W-1:0]     alloc;
  logic [NUM_SLOTS-1:0] running;
  logic [IDX_W-1:0]     proc_idx;
  logic                 pend_valid;
  logic [IDX_W-1:0]     pend_idx;

  logic               accept;
  logic               full;
  logic [IDX_W-1:0]   new_slot;
  logic [IDX_W-1:0]   top_slot;
  logic signed [31:0] dec;
  logic               active;
  logic               expired;

  assign accept   = start && (state == S_IDLE);
  assign busy     = (state != S_IDLE);
  assign full     = (32'(alloc) >= 32'(pool_limit)) || (32'(alloc) >= NUM_SLOTS);
  assign new_slot = alloc[IDX_W-1:0];
  assign top_slot = IDX_W'(alloc - CNT_W'(1));
  assign dec      = rd_data.count - 32'sd1;
  assign active   = (state == S_WALK) && running[proc_idx];
  assign expired  = active && (dec <= 32'sd0);

  always_comb begin
    mreq = '0;
    if (accept && request.kind == KIND_CREATE && !full) begin
      mreq.wr_en                = 1'b1;
      mreq.wr_addr              = new_slot;
      mreq.wr_data.reload       = request.init_count;
      mreq.wr_data.count        = signed'({1'b0, request.init_count});
      mreq.wr_data.one_shot     = request.one_shot;
    end else if (accept && request.kind == KIND_TICK && alloc != '0) begin
      mreq.rd_en   = 1'b1;
      mreq.rd_addr = top_slot;
    end else if (state == S_WALK) begin
      mreq.rd_en   = (proc_idx != '0);
      mreq.rd_addr = proc_idx - IDX_W'(1);
      mreq.wr_en   = active;
      mreq.wr_addr = proc_idx;
      mreq.wr_data = rd_data;
      if (expired && !rd_data.one_shot) begin
        mreq.wr_data.count = signed'({1'b0, rd_data.reload});
      end else begin
        mreq.wr_data.count = dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      alloc      <= '0;
      running    <= '0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (request.kind == KIND_CREATE) begin
              done <= 1'b1;
              result.last <= 1'b1;
              if (full) begin
                result.event_kind  <= EV_REFUSED;
                result.timer_index <= '0;
              end else begin
                result.event_kind  <= EV_CREATED;
                result.timer_index <= 4'(new_slot);
                running[new_slot]  <= 1'b1;
                alloc              <= alloc + CNT_W'(1);
              end
            end else if (alloc != '0) begin
              state      <= S_WALK;
              proc_idx   <= top_slot;
              pend_valid <= 1'b0;
            end
          end
        end
        S_WALK: begin
          if (expired) begin
            if (rd_data.one_shot) begin
              running[proc_idx] <= 1'b0;
            end
            if (pend_valid) begin
              done               <= 1'b1;
              result.event_kind  <= EV_TIMEOUT;
              result.timer_index <= 4'(pend_idx);
              result.last        <= 1'b0;
            end
            pend_valid <= 1'b1;
            pend_idx   <= proc_idx;
          end
          if (proc_idx == '0) begin
            state <= S_FLUSH;
          end else begin
            proc_idx <= proc_idx - IDX_W'(1);
          end
        end
        S_FLUSH: begin
          if (pend_valid) begin
            done               <= 1'b1;
            result.event_kind  <= EV_TIMEOUT;
            result.timer_index <= 4'(pend_idx);
            result.last        <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    32'(alloc) <= NUM_SLOTS)
    else $error("allocation count beyond pool");

  a_walk_wr_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && mreq.wr_en) |-> (32'(mreq.wr_addr) < 32'(alloc)))
    else $error("tick write-back outside allocated slots");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (state == S_IDLE))
    else $error("flush did not return to idle");

  a_final_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH && pend_valid) |=> (done && result.last))
    else $error("final timeout missing last mark");

endmodule

// ----- sv/periodic_oneshot_timer_bank_core.sv -----
// Top level of the periodic/one-shot timer bank: config register, sequencer, entry memory.
//
//  channel   ports                        handshake
//  --------  ---------------------------  ----------------------------------
//  command   start, busy, request         taken when start && !busy
//  result    done, result                 one-cycle strobe, no back-pressure
//  config    cfg_we, cfg_data             written when cfg_we is high
//
// A create is handled when accepted; its result follows on the next cycle.
// A tick walks the allocated slots (at most NUM_SLOTS) from the highest down:
// one memory read per slot plus a final flush, bound by the single read port.
// A tick with no allocated slots gives no result and does not raise busy.
// Reset clears running flags, the slot count and sets pool_limit to 16.
// Results are strobed at most one per cycle and must be taken at once.
module periodic_oneshot_timer_bank_core
  import potb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  item_in_t           request,
  output logic               busy,
  output logic               done,
  output item_out_t          result,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0] pool_limit;
  mem_req_t           mreq;
  entry_t             rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_limit <= LIMIT_W'(16);
    end else if (cfg_we) begin
      pool_limit <= cfg_data;
    end
  end

  potb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .request    (request),
    .pool_limit (pool_limit),
    .busy       (busy),
    .done       (done),
    .result     (result),
    .mreq       (mreq),
    .rd_data    (rd_data)
  );

  potb_store u_store (
    .clk     (clk),
    .mreq    (mreq),
    .rd_data (rd_data)
  );

endmodule
